// ===== rtl/sstep_pkg.sv =====
// Shared types, constants and state encoding for the step/direction pulse generator.
package sstep_pkg;

    localparam int unsigned FREQ_W  = 19;
    localparam int unsigned CUT_W   = 16;
    localparam int unsigned SPEED_W = 17;
    localparam int unsigned MAG_W   = 16;
    localparam int unsigned CNT_W   = 20;
    localparam int unsigned QUOT_W  = 20;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam int unsigned MUL_STEPS = MAG_W;
    localparam int unsigned DIV_STEPS = QUOT_W;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int unsigned PROD_W    = CNT_W + MAG_W;

    localparam logic [QUOT_W-1:0] TICK_RATE_HZ = 20'd1000000;
    localparam logic [MAG_W-1:0]  FULL_SCALE   = 16'h8000;

    localparam logic [FREQ_W-1:0] MIN_FREQ_RST = 19'd100;
    localparam logic [FREQ_W-1:0] MAX_FREQ_RST = 19'd10000;
    localparam logic [CUT_W-1:0]  CUTOFF_RST   = 16'd328;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_MIN_FREQ = 2'd0;
    localparam reg_idx_t REG_MAX_FREQ = 2'd1;
    localparam reg_idx_t REG_CUTOFF   = 2'd2;

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic [CNT_W-1:0]          count_t;
    typedef logic [FREQ_W-1:0]         freq_t;

    typedef struct packed {
        freq_t             min_freq;
        freq_t             max_freq;
        logic [CUT_W-1:0]  cutoff;
    } cfg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

endpackage

// ===== rtl/sstep_if.sv =====
// Valid/ready channel interfaces for input commands and output results.
interface sstep_in_if;
    logic                 valid;
    logic                 ready;
    logic                 func;
    sstep_pkg::speed_t    speed_cmd;

    modport source (output valid, output func, output speed_cmd, input ready);
    modport sink   (input valid, input func, input speed_cmd, output ready);
endinterface

interface sstep_out_if;
    logic                 valid;
    logic                 ready;
    logic                 step_level;
    logic                 dir_level;
    logic                 running;
    sstep_pkg::count_t    period_ticks;

    modport source (output valid, output step_level, output dir_level, output running,
                    output period_ticks, input ready);
    modport sink   (input valid, input step_level, input dir_level, input running,
                    input period_ticks, output ready);
endinterface

// ===== rtl/sstep_apb_regs.sv =====
// APB configuration registers for the step frequency range and speed cutoff.
module sstep_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sstep_pkg::ADDR_W-1:0] paddr,
    input  logic [sstep_pkg::DATA_W-1:0] pwdata,
    output logic [sstep_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output sstep_pkg::cfg_t             cfg
);
    import sstep_pkg::*;

    freq_t            min_freq_reg;
    freq_t            max_freq_reg;
    logic [CUT_W-1:0] cutoff_reg;
    reg_idx_t         idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_freq_reg <= MIN_FREQ_RST;
            max_freq_reg <= MAX_FREQ_RST;
            cutoff_reg   <= CUTOFF_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MIN_FREQ: min_freq_reg <= pwdata[FREQ_W-1:0];
                REG_MAX_FREQ: max_freq_reg <= pwdata[FREQ_W-1:0];
                REG_CUTOFF:   cutoff_reg   <= pwdata[CUT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MIN_FREQ: prdata = {{(DATA_W-FREQ_W){1'b0}}, min_freq_reg};
            REG_MAX_FREQ: prdata = {{(DATA_W-FREQ_W){1'b0}}, max_freq_reg};
            REG_CUTOFF:   prdata = {{(DATA_W-CUT_W){1'b0}}, cutoff_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.min_freq = min_freq_reg;
    assign cfg.max_freq = max_freq_reg;
    assign cfg.cutoff   = cutoff_reg;

endmodule

// ===== rtl/sstep_mul.sv =====
// Bit-serial shift-and-add multiplier giving the scaled frequency span.
module sstep_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  sstep_pkg::freq_t             span,
    input  logic [sstep_pkg::MAG_W-1:0]  mag,
    output logic                         done,
    output sstep_pkg::freq_t             scaled
);
    import sstep_pkg::*;

    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    freq_t                span_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     upper;
    logic [CNT_W-1:0]     upper_sum;
    logic                 last;

    assign upper     = prod_reg[PROD_W-1:MAG_W];
    assign upper_sum = prod_reg[0] ? upper + {1'b0, span_reg} : upper;
    assign prod_next = {1'b0, upper_sum, prod_reg[MAG_W-1:1]};
    assign last      = (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            span_reg <= span;
            prod_reg <= {{CNT_W{1'b0}}, mag};
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign done   = done_reg;
    assign scaled = prod_reg[MAG_W-2+FREQ_W:MAG_W-1];

endmodule

// ===== rtl/sstep_div.sv =====
// Restoring divider, one quotient bit per cycle, dividing the tick rate by the step frequency.
module sstep_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sstep_pkg::freq_t   divisor,
    output logic               done,
    output sstep_pkg::count_t  quotient
);
    import sstep_pkg::*;

    freq_t                rem_reg;
    logic [QUOT_W-1:0]    quo_reg;
    freq_t                dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [FREQ_W:0]      trial;
    logic [FREQ_W:0]      diff;
    logic                 fits;
    logic                 last;

    assign trial = {rem_reg, quo_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign last  = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= TICK_RATE_HZ;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
            quo_reg <= {quo_reg[QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/speed_to_step_dir_pulse_generator.sv =====
// Top level: speed commands and timer ticks in, step, direction and period results out.
// A tick, or a speed command below the cutoff, goes straight to S_DONE after acceptance;
// a command that starts or retimes pulsing passes first through the serial multiplier and
// then the serial divider (S_MUL, S_DIV). One transaction is processed at a time, so the
// next is accepted only after the previous result has been loaded into the output registers.
// Asynchronous reset stops pulsing, clears the counters and loads the register defaults.
module speed_to_step_dir_pulse_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sstep_pkg::ADDR_W-1:0]  paddr,
    input  logic [sstep_pkg::DATA_W-1:0]  pwdata,
    output logic [sstep_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    sstep_in_if.sink                      in_ch,
    sstep_out_if.source                   out_ch
);
    import sstep_pkg::*;

    cfg_t             cfg;
    state_t           state_reg;
    state_t           state_next;

    count_t           tick_reg;
    count_t           tick_next;
    count_t           reload_reg;
    count_t           reload_next;
    count_t           high_reg;
    count_t           high_next;
    logic             run_reg;
    logic             run_next;
    logic             dir_reg;
    logic             dir_next;

    logic             out_valid_reg;
    logic             step_out_reg;
    logic             dir_out_reg;
    logic             run_out_reg;
    count_t           period_out_reg;

    logic             accept;
    logic             out_free;
    logic             load_out;
    logic             mul_start;
    logic             mul_done;
    logic             div_start;
    logic             div_done;
    freq_t            hi_eff;
    freq_t            span;
    freq_t            scaled;
    logic [FREQ_W:0]  freq_sum;
    freq_t            freq;
    count_t           quotient;

    logic             neg;
    logic [SPEED_W-1:0] abs_val;
    logic [MAG_W-1:0] mag;
    logic             below_cut;

    sstep_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign hi_eff = (cfg.max_freq < cfg.min_freq) ? cfg.min_freq : cfg.max_freq;
    assign span   = hi_eff - cfg.min_freq;

    assign neg       = in_ch.speed_cmd[SPEED_W-1];
    assign abs_val   = neg ? (~in_ch.speed_cmd + 1'b1) : in_ch.speed_cmd;
    assign mag       = (abs_val > {1'b0, FULL_SCALE}) ? FULL_SCALE : abs_val[MAG_W-1:0];
    assign below_cut = (mag < cfg.cutoff);

    sstep_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .span   (span),
        .mag    (mag),
        .done   (mul_done),
        .scaled (scaled)
    );

    assign freq_sum = {1'b0, cfg.min_freq} + {1'b0, scaled};
    assign freq     = (freq_sum[FREQ_W-1:0] == '0) ? FREQ_W'(1) : freq_sum[FREQ_W-1:0];

    sstep_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (freq),
        .done     (div_done),
        .quotient (quotient)
    );

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.func || below_cut)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready = 1'b0;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                mul_start   = in_ch.valid && !in_ch.func && !below_cut;
            end
            S_MUL:  div_start = mul_done;
            S_DIV:  ;
            S_DONE: load_out = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        tick_next   = tick_reg;
        reload_next = reload_reg;
        high_next   = high_reg;
        run_next    = run_reg;
        dir_next    = dir_reg;
        if (accept && in_ch.func)
        begin
            if (run_reg)
            begin
                tick_next = (tick_reg >= reload_reg) ? '0 : tick_reg + 1'b1;
            end
        end
        else if (accept)
        begin
            dir_next = !neg;
            if (below_cut)
            begin
                run_next = 1'b0;
            end
        end
        if (div_done && state_reg == S_DIV)
        begin
            reload_next = (quotient == '0) ? '0 : quotient - 1'b1;
            high_next   = quotient >> 1;
            if (!run_reg)
            begin
                tick_next = '0;
                run_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            reload_reg    <= '0;
            high_reg      <= '0;
            run_reg       <= 1'b0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            reload_reg <= reload_next;
            high_reg   <= high_next;
            run_reg    <= run_next;
            dir_reg    <= dir_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            step_out_reg   <= run_reg && (tick_reg < high_reg);
            dir_out_reg    <= dir_reg;
            run_out_reg    <= run_reg;
            period_out_reg <= reload_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.step_level   = step_out_reg;
    assign out_ch.dir_level    = dir_out_reg;
    assign out_ch.running      = run_out_reg;
    assign out_ch.period_ticks = period_out_reg;

endmodule
